// File: rtl/pfss_pkg.sv
package pfss_pkg;

    // Frequency word width and padded stream widths.
    localparam int FREQ_W     = 18;
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Event codes carried on the input tuser field.
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_START  = 3'd1;
    localparam logic [2:0] FUNC_STOP   = 3'd2;
    localparam logic [2:0] FUNC_FAULT  = 3'd3;
    localparam logic [2:0] FUNC_RAMP   = 3'd4;
    localparam logic [2:0] FUNC_CANCEL = 3'd5;

    // Soft-start phase codes.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SWEEP = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;
    localparam logic [1:0] PH_FAULT = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STARTUP_BAND   = 3'd0;
    localparam logic [2:0] CFG_LOW_TARGET     = 3'd1;
    localparam logic [2:0] CFG_HIGH_TARGET    = 3'd2;
    localparam logic [2:0] CFG_FREQ_MIN       = 3'd3;
    localparam logic [2:0] CFG_FREQ_MAX       = 3'd4;
    localparam logic [2:0] CFG_SWEEP_PERIOD   = 3'd5;
    localparam logic [2:0] CFG_RAMP_STEP      = 3'd6;
    localparam logic [2:0] CFG_RAMP_PERIOD    = 3'd7;

    // Sweep constants.
    localparam logic [FREQ_W-1:0] LOW_START      = 18'd99900;
    localparam logic [FREQ_W-1:0] HIGH_START     = 18'd200000;
    localparam logic [FREQ_W-1:0] LOW_DEF_END    = 18'd20000;
    localparam logic [FREQ_W-1:0] HIGH_DEF_END   = 18'd100000;
    localparam logic [9:0]        LOW_STEP       = 10'd100;
    localparam logic [9:0]        HIGH_STEP      = 10'd1000;
    localparam logic [FREQ_W-1:0] LOW_TARGET_MAX = 18'd99900;

    // Configuration register file as seen by the core.
    typedef struct packed {
        logic              startup_band;
        logic [16:0]       low_target_hz;
        logic [FREQ_W-1:0] high_target_hz;
        logic [FREQ_W-1:0] freq_min_hz;
        logic [FREQ_W-1:0] freq_max_hz;
        logic [7:0]        sweep_period_ms;
        logic [15:0]       ramp_step_hz;
        logic [7:0]        ramp_period_ms;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic              freq_written;
        logic              ramp_busy;
        logic [1:0]        ss_phase;
        logic              pwm_enable;
        logic [FREQ_W-1:0] freq_hz;
    } t_result;

    // Driver clamp: raise to the minimum, then lower to the maximum.
    function automatic logic [FREQ_W-1:0] drv_clamp(input logic [FREQ_W-1:0] f,
                                                   input logic [FREQ_W-1:0] fmin,
                                                   input logic [FREQ_W-1:0] fmax);
        logic [FREQ_W-1:0] v;
        v = (f < fmin) ? fmin : f;
        v = (v > fmax) ? fmax : v;
        return v;
    endfunction

    // Multiple of 100: low two bits clear and the quarter divisible by 25.
    // Divisibility by 25 uses the modular inverse of 25 modulo 2^15.
    function automatic logic is_mult100(input logic [16:0] x);
        logic [14:0] p;
        p = 15'(x[16:2] * 15'd23593);
        return (x[1:0] == 2'd0) && (p <= 15'd1310);
    endfunction

    // Multiple of 1000: low three bits clear and the eighth divisible by 125.
    function automatic logic is_mult1000(input logic [FREQ_W-1:0] x);
        logic [14:0] p;
        p = 15'(x[17:3] * 15'd30933);
        return (x[2:0] == 3'd0) && (p <= 15'd262);
    endfunction

endpackage

// File: rtl/pwm_freq_soft_start_ramp_top.sv
// Inverter drive frequency sequencer with soft start and run-time ramp.
// Input stream: each transaction is one event; s_axis_tuser carries the event
// code (tick, start, stop, fault, ramp to target, ramp cancel) and
// s_axis_tdata carries the ramp target in its low 18 bits.
// Output stream: exactly one result transaction per event with the frequency,
// drive enable, soft-start phase, ramp busy flag and a frequency-written flag.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is
// high; only while no event is in flight.
// Path: an event passes the input register, then the event logic into the
// result buffer, from which its result is offered.
// Throughput: one event per cycle while s_axis_tready is high; the sequencer
// state updates per event, so consecutive events see each other's effects.
// Stall: a two-entry result buffer sits at the output; s_axis_tready drops
// when it has no slot beside the one kept for the event already registered.
// Reset: synchronous active-low i_rst_n restores the default registers,
// returns the sequencer to idle at 200 kHz with the drive off and empties the
// result buffer.
module pwm_freq_soft_start_ramp_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Event input.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [17:0] ramp target frequency, [23:18] zero
    input  logic [pfss_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [2:0] func
    input  logic [pfss_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // Result output.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [17:0] freq_hz, [18] pwm_enable, [20:19] ss_phase, [21] ramp_busy,
    // [22] freq_written, [23] zero
    output logic [pfss_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [pfss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pfss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pfss_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [2:0]        r_in_func;
    logic [FREQ_W-1:0] r_in_target;
    logic              in_take;
    logic              push;
    t_result           core_res;
    t_result           out_res;
    logic [1:0]        room;

    // Accept while the buffer keeps a slot for the event already registered.
    assign s_axis_tready = room > {1'b0, r_in_valid};
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_band    <= 1'b1;
            r_cfg.low_target_hz   <= 17'd20000;
            r_cfg.high_target_hz  <= 18'd100000;
            r_cfg.freq_min_hz     <= 18'd1000;
            r_cfg.freq_max_hz     <= 18'd200000;
            r_cfg.sweep_period_ms <= 8'd10;
            r_cfg.ramp_step_hz    <= 16'd1000;
            r_cfg.ramp_period_ms  <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STARTUP_BAND: r_cfg.startup_band    <= i_cfg_data[0];
                CFG_LOW_TARGET:   r_cfg.low_target_hz   <= i_cfg_data[16:0];
                CFG_HIGH_TARGET:  r_cfg.high_target_hz  <= i_cfg_data[FREQ_W-1:0];
                CFG_FREQ_MIN:     r_cfg.freq_min_hz     <= i_cfg_data[FREQ_W-1:0];
                CFG_FREQ_MAX:     r_cfg.freq_max_hz     <= i_cfg_data[FREQ_W-1:0];
                CFG_SWEEP_PERIOD: r_cfg.sweep_period_ms <= i_cfg_data[7:0];
                CFG_RAMP_STEP:    r_cfg.ramp_step_hz    <= i_cfg_data[15:0];
                CFG_RAMP_PERIOD:  r_cfg.ramp_period_ms  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func   <= s_axis_tuser;
            r_in_target <= s_axis_tdata[FREQ_W-1:0];
        end
    end

    // Event logic and sequencer state.
    pfss_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_func        (r_in_func),
        .i_ramp_target (r_in_target),
        .i_cfg         (r_cfg),
        .o_push        (push),
        .o_res         (core_res)
    );

    // Result buffer.
    pfss_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (core_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res),
        .o_room  (room)
    );

    // Pack the result fields, highest bit first.
    assign m_axis_tdata = {1'b0, out_res.freq_written, out_res.ramp_busy,
                           out_res.ss_phase, out_res.pwm_enable, out_res.freq_hz};

endmodule

// File: rtl/pfss_core.sv
module pfss_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [2:0]              i_func,
    input  logic [17:0]             i_ramp_target,
    input  pfss_pkg::t_cfg          i_cfg,
    output logic                    o_push,
    output pfss_pkg::t_result       o_res
);
    import pfss_pkg::*;

    // Sequencer state.
    logic [1:0]        r_phase, n_phase;
    logic [FREQ_W-1:0] r_out_freq, n_out_freq;
    logic [FREQ_W-1:0] r_req_freq, n_req_freq;
    logic [FREQ_W-1:0] r_sweep_start, n_sweep_start;
    logic [FREQ_W-1:0] r_sweep_end, n_sweep_end;
    logic [9:0]        r_sweep_step, n_sweep_step;
    logic [7:0]        r_sweep_elapsed, n_sweep_elapsed;
    logic [FREQ_W-1:0] r_ramp_goal, n_ramp_goal;
    logic              r_ramp_on, n_ramp_on;
    logic [7:0]        r_ramp_elapsed, n_ramp_elapsed;
    logic              r_drive_on, n_drive_on;
    logic              wrote;

    // Soft-start step terms.
    logic [7:0]        sw_el_inc;
    logic              sw_fire;
    logic              sw_end_hit;
    logic [FREQ_W-1:0] sw_req;
    logic [FREQ_W-1:0] sw_out;

    // Ramp step terms.
    logic [FREQ_W-1:0] rp_cur;
    logic [FREQ_W-1:0] rp_dist;
    logic              rp_near;
    logic [7:0]        rp_el_inc;
    logic              rp_fire;
    logic [FREQ_W:0]   rp_up;
    logic [FREQ_W:0]   rp_goal_plus;
    logic [FREQ_W-1:0] rp_val;

    // Start terms.
    logic              cfg_ok;
    logic              st_band;
    logic [FREQ_W-1:0] st_start;
    logic [FREQ_W-1:0] st_end;
    logic [9:0]        st_step;

    // Ramp trigger goal.
    logic [FREQ_W-1:0] rq_goal;

    // Soft-start step: the period counter saturates and fires at the period.
    assign sw_el_inc  = (r_sweep_elapsed == 8'd255) ? 8'd255 : r_sweep_elapsed + 8'd1;
    assign sw_fire    = (r_phase == PH_SWEEP) && (sw_el_inc >= i_cfg.sweep_period_ms);
    assign sw_end_hit = ({1'b0, r_req_freq}) <=
                        ({1'b0, r_sweep_end} + {9'd0, r_sweep_step});
    assign sw_req     = sw_end_hit ? r_sweep_end : r_req_freq - {8'd0, r_sweep_step};
    assign sw_out     = drv_clamp(sw_req, i_cfg.freq_min_hz, i_cfg.freq_max_hz);

    // Ramp step sees the frequency the soft-start step just wrote.
    assign rp_cur     = sw_fire ? sw_out : r_out_freq;
    assign rp_dist    = (rp_cur >= r_ramp_goal) ? rp_cur - r_ramp_goal : r_ramp_goal - rp_cur;
    assign rp_near    = rp_dist <= {2'd0, i_cfg.ramp_step_hz};
    assign rp_el_inc  = (r_ramp_elapsed == 8'd255) ? 8'd255 : r_ramp_elapsed + 8'd1;
    assign rp_fire    = rp_el_inc >= i_cfg.ramp_period_ms;
    assign rp_up        = {1'b0, rp_cur} + {3'd0, i_cfg.ramp_step_hz};
    assign rp_goal_plus = {1'b0, r_ramp_goal} + {3'd0, i_cfg.ramp_step_hz};

    always_comb begin
        if (rp_cur < r_ramp_goal) begin
            rp_val = (rp_up > {1'b0, r_ramp_goal}) ? r_ramp_goal : rp_up[FREQ_W-1:0];
        end else if ({1'b0, rp_cur} < rp_goal_plus) begin
            rp_val = r_ramp_goal;
        end else begin
            rp_val = rp_cur - {2'd0, i_cfg.ramp_step_hz};
        end
    end

    // Startup configuration check; invalid settings fall back to the defaults.
    assign cfg_ok = ({1'b0, i_cfg.low_target_hz} >= i_cfg.freq_min_hz) &&
                    ({1'b0, i_cfg.low_target_hz} <= LOW_TARGET_MAX) &&
                    is_mult100(i_cfg.low_target_hz) &&
                    (i_cfg.high_target_hz >= HIGH_DEF_END) &&
                    (i_cfg.high_target_hz <= i_cfg.freq_max_hz) &&
                    is_mult1000(i_cfg.high_target_hz);
    assign st_band  = cfg_ok ? i_cfg.startup_band : 1'b1;
    assign st_start = st_band ? HIGH_START : LOW_START;
    assign st_step  = st_band ? HIGH_STEP : LOW_STEP;

    always_comb begin
        if (!cfg_ok) begin
            st_end = st_band ? HIGH_DEF_END : LOW_DEF_END;
        end else if (st_band) begin
            st_end = i_cfg.high_target_hz;
        end else begin
            st_end = {1'b0, i_cfg.low_target_hz};
        end
    end

    assign rq_goal = drv_clamp(i_ramp_target, i_cfg.freq_min_hz, i_cfg.freq_max_hz);

    // Next-state selection for one event.
    always_comb begin
        n_phase         = r_phase;
        n_out_freq      = r_out_freq;
        n_req_freq      = r_req_freq;
        n_sweep_start   = r_sweep_start;
        n_sweep_end     = r_sweep_end;
        n_sweep_step    = r_sweep_step;
        n_sweep_elapsed = r_sweep_elapsed;
        n_ramp_goal     = r_ramp_goal;
        n_ramp_on       = r_ramp_on;
        n_ramp_elapsed  = r_ramp_elapsed;
        n_drive_on      = r_drive_on;
        wrote           = 1'b0;
        if (i_valid) begin
            case (i_func)
                FUNC_TICK: begin
                    if (sw_fire) begin
                        n_sweep_elapsed = 8'd0;
                        n_req_freq      = sw_req;
                        n_out_freq      = sw_out;
                        if (sw_end_hit) begin
                            n_phase = PH_DONE;
                        end
                    end else if (r_phase == PH_SWEEP) begin
                        n_sweep_elapsed = sw_el_inc;
                    end
                    if (r_ramp_on) begin
                        if (rp_near) begin
                            n_out_freq = drv_clamp(r_ramp_goal, i_cfg.freq_min_hz,
                                                   i_cfg.freq_max_hz);
                            n_ramp_on  = 1'b0;
                        end else if (rp_fire) begin
                            n_ramp_elapsed = 8'd0;
                            n_out_freq     = drv_clamp(rp_val, i_cfg.freq_min_hz,
                                                       i_cfg.freq_max_hz);
                        end else begin
                            n_ramp_elapsed = rp_el_inc;
                        end
                    end
                    wrote = sw_fire || (r_ramp_on && (rp_near || rp_fire));
                end
                FUNC_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_sweep_start   = st_start;
                        n_sweep_end     = st_end;
                        n_sweep_step    = st_step;
                        n_req_freq      = st_start;
                        n_ramp_on       = 1'b0;
                        n_out_freq      = drv_clamp(st_start, i_cfg.freq_min_hz,
                                                    i_cfg.freq_max_hz);
                        n_drive_on      = 1'b1;
                        n_sweep_elapsed = 8'd0;
                        n_phase         = PH_SWEEP;
                        wrote           = 1'b1;
                    end
                end
                FUNC_STOP: begin
                    // Stop returns to the sweep start without a driver write.
                    n_drive_on = 1'b0;
                    n_req_freq = r_sweep_start;
                    n_out_freq = r_sweep_start;
                    n_ramp_on  = 1'b0;
                    n_phase    = PH_IDLE;
                end
                FUNC_FAULT: begin
                    n_drive_on = 1'b0;
                    n_ramp_on  = 1'b0;
                    n_phase    = PH_FAULT;
                end
                FUNC_RAMP: begin
                    n_ramp_goal    = rq_goal;
                    n_ramp_on      = 1'b1;
                    n_ramp_elapsed = 8'd0;
                end
                FUNC_CANCEL: begin
                    n_ramp_on = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_out_freq      <= HIGH_START;
            r_req_freq      <= HIGH_START;
            r_sweep_start   <= HIGH_START;
            r_sweep_end     <= HIGH_DEF_END;
            r_sweep_step    <= HIGH_STEP;
            r_sweep_elapsed <= 8'd0;
            r_ramp_goal     <= '0;
            r_ramp_on       <= 1'b0;
            r_ramp_elapsed  <= 8'd0;
            r_drive_on      <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_out_freq      <= n_out_freq;
            r_req_freq      <= n_req_freq;
            r_sweep_start   <= n_sweep_start;
            r_sweep_end     <= n_sweep_end;
            r_sweep_step    <= n_sweep_step;
            r_sweep_elapsed <= n_sweep_elapsed;
            r_ramp_goal     <= n_ramp_goal;
            r_ramp_on       <= n_ramp_on;
            r_ramp_elapsed  <= n_ramp_elapsed;
            r_drive_on      <= n_drive_on;
        end
    end

    // The result reports the state after the event.
    assign o_push              = i_valid;
    assign o_res.freq_hz       = n_out_freq;
    assign o_res.pwm_enable    = n_drive_on;
    assign o_res.ss_phase      = n_phase;
    assign o_res.ramp_busy     = n_ramp_on;
    assign o_res.freq_written  = wrote;

    // A stop always leaves the drive off, the ramp off and the phase idle.
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_func == FUNC_STOP) |=> (r_phase == PH_IDLE && !r_drive_on && !r_ramp_on))
        else $error("stop did not return the sequencer to idle");

    // A fault turns the drive off and holds the fault phase.
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_func == FUNC_FAULT) |=> (r_phase == PH_FAULT && !r_drive_on))
        else $error("fault did not disable the drive");

    // A start taken in idle begins a sweep with the drive on.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_func == FUNC_START && r_phase == PH_IDLE)
        |=> (r_phase == PH_SWEEP && r_drive_on && !r_ramp_on))
        else $error("start from idle did not begin a sweep");

    // The fault phase is only left through a stop.
    a_fault_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FAULT && !(i_valid && i_func == FUNC_STOP)) |=> (r_phase == PH_FAULT))
        else $error("fault phase left without a stop");

endmodule

// File: rtl/pfss_outq.sv
module pfss_outq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  pfss_pkg::t_result       i_res,
    output logic                    o_valid,
    input  logic                    i_ready,
    output pfss_pkg::t_result       o_res,
    output logic [1:0]              o_room
);
    import pfss_pkg::*;

    // Two-entry result buffer so input and output sides stall independently.
    t_result    r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_res   = r_q[r_rd_ptr];
    // Free slots once this cycle's pop is counted.
    assign o_room  = 2'd2 - r_count + {1'b0, pop};

    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // The buffer never holds more than two results.
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result buffer level out of range");

    // A push never lands on a full buffer unless a result leaves together.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_count == 2'd2) |-> pop)
        else $error("result buffer overflow");

    // The level matches the difference of the pointers.
    a_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("result buffer pointers disagree with level");

endmodule
